// File: hdl/tvc_pkg.sv
// Shared constants and types of the tolerance value clustering block.
`default_nettype none

package tvc_pkg;

    // Largest number of values in one set, and the ring length.
    localparam int MAX_VALUES = 64;

    localparam int VAL_W  = 31;
    localparam int IDX_W  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W  = $clog2(MAX_VALUES + 1);
    localparam int SUM_W  = 37;
    localparam int MASK_W = 64;
    localparam int DIV_CW = $clog2(SUM_W + 1);

    // Smallest tolerance that still puts the seed into its own group.
    localparam logic [VAL_W-1:0] TOL_MIN = VAL_W'(2);

    // Control that every cell of the ring sees.
    typedef struct packed {
        logic shift;
        logic clr;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: hdl/tvc_cell.sv
// One cell of the value ring: a stored value and its taken flag.
`default_nettype none

module tvc_cell
    import tvc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic             i_wr_en,
    input  wire logic [VAL_W-1:0] i_wr_value,
    input  wire logic [VAL_W-1:0] i_nb_value,
    input  wire logic             i_nb_taken,
    output logic      [VAL_W-1:0] o_value,
    output logic                  o_taken
);

    logic [VAL_W-1:0] r_value;
    logic             r_taken;

    // Loading writes only while the ring stands still.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_value <= i_wr_value;
        end else if (i_ctrl.shift) begin
            r_value <= i_nb_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_taken <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_taken <= i_nb_taken;
        end
    end

    assign o_value = r_value;
    assign o_taken = r_taken;

endmodule

`default_nettype wire

// File: hdl/tvc_div.sv
// Restoring divider, one quotient bit per cycle, for the group average.
`default_nettype none

module tvc_div
    import tvc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [SUM_W-1:0] o_quot
);

    logic [SUM_W-1:0]  r_dvd;
    logic [SUM_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_done;
    logic [CNT_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_dvd  <= {r_dvd[SUM_W-2:0], 1'b0};
            r_quot <= {r_quot[SUM_W-2:0], w_fit};
            // The remainder stays below the divisor, so it fits CNT_W bits.
            r_rem  <= w_fit ? CNT_W'(w_trial - {1'b0, r_dsr}) : CNT_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_cnt <= DIV_CW'(SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: hdl/tolerance_value_clustering.sv
// Top level of the tolerance value clustering block: load ring, grouping passes, results.
//
//   channel   | handshake                         | payload
//   ----------+-----------------------------------+--------------------------------------
//   input     | start in, busy out                | i_value, i_last
//   result    | o_result_valid strobe, no stall   | o_average, o_members, o_last_group
//   config    | i_cfg_valid in, o_cfg_ready out   | i_cfg_data (tolerance)
//
// While loading, one beat is taken per cycle; busy stays low until a beat with i_last.
// The last beat starts the grouping. Each group takes one full turn of the value ring,
// a divider launch, the bit-serial divide with its done flag, and the result strobe.
// The first group first passes a start state that picks up the first seed.
// Reset is synchronous and clears the control state; the stored values are not cleared.
// Results appear as one-cycle strobes; the receiver cannot stall them.
`default_nettype none

module tolerance_value_clustering
    import tvc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic              i_last,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [VAL_W-1:0]  i_cfg_data,
    output logic                   o_result_valid,
    output logic      [VAL_W-1:0]  o_average,
    output logic      [MASK_W-1:0] o_members,
    output logic                   o_last_group
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_PASS  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [VAL_W-1:0]      r_tol;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_step, n_step;
    logic [VAL_W-1:0]      r_seed, n_seed;
    logic [VAL_W-1:0]      r_next_seed, n_next_seed;
    logic                  r_found, n_found;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [CNT_W-1:0]      r_gcnt, n_gcnt;
    logic [MAX_VALUES-1:0] r_mask, n_mask;
    logic [VAL_W-1:0]      r_avg, n_avg;

    logic                  w_accept;
    t_cell_ctrl            w_ctrl;
    logic [VAL_W-1:0]      w_value [MAX_VALUES];
    logic                  w_taken [MAX_VALUES];
    logic [VAL_W-1:0]      w_tol_eff;
    logic [VAL_W-2:0]      w_half;
    logic [VAL_W:0]        w_hi;
    logic                  w_in_set;
    logic                  w_hit;
    logic                  w_member;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [SUM_W-1:0]      w_quot;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = !busy;

    // Tolerance register; below two it acts as two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_MIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    assign w_tol_eff = (r_tol < TOL_MIN) ? TOL_MIN : r_tol;
    assign w_half    = w_tol_eff[VAL_W-1:1];

    // Window test on the value at the head of the ring (cell 0). The window is open on
    // both sides; when the seed is below the half width the lower bound is negative.
    assign w_hi     = {1'b0, r_seed} + {2'b00, w_half};
    assign w_hit    = ({1'b0, w_value[0]} < w_hi) &&
                      ((r_seed < {1'b0, w_half}) ||
                       (w_value[0] > (r_seed - {1'b0, w_half})));
    assign w_in_set = CNT_W'(r_step) < r_count;
    assign w_member = (r_state == S_PASS) && w_in_set && w_hit;

    assign w_ctrl.shift = (r_state == S_PASS);
    assign w_ctrl.clr   = (r_state == S_START);

    // The ring turns toward cell 0; cell 0 feeds the last cell, with its taken flag
    // updated by the current group. After a full turn every value is back in place.
    for (genvar k = 0; k < MAX_VALUES; k++) begin : g_cell
        logic [VAL_W-1:0] w_nb_value;
        logic             w_nb_taken;
        if (k == MAX_VALUES - 1) begin : g_tail
            assign w_nb_value = w_value[0];
            assign w_nb_taken = w_taken[0] | w_member;
        end else begin : g_body
            assign w_nb_value = w_value[k+1];
            assign w_nb_taken = w_taken[k+1];
        end
        tvc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_wr_en    (w_accept && (r_count == CNT_W'(k))),
            .i_wr_value (i_value),
            .i_nb_value (w_nb_value),
            .i_nb_taken (w_nb_taken),
            .o_value    (w_value[k]),
            .o_taken    (w_taken[k])
        );
    end

    assign w_div_start = (r_state == S_DIV);

    tvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_gcnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_seed      = r_seed;
        n_next_seed = r_next_seed;
        n_found     = r_found;
        n_sum       = r_sum;
        n_gcnt      = r_gcnt;
        n_mask      = r_mask;
        n_avg       = r_avg;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Values past the ring length are dropped, but i_last still counts.
                    if (r_count < CNT_W'(MAX_VALUES)) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_seed  = w_value[0];
                n_step  = '0;
                n_found = 1'b0;
                n_sum   = '0;
                n_gcnt  = '0;
                n_mask  = '0;
                n_state = S_PASS;
            end
            S_PASS: begin
                n_mask = {w_member, r_mask[MAX_VALUES-1:1]};
                if (w_member) begin
                    n_sum  = r_sum + SUM_W'(w_value[0]);
                    n_gcnt = r_gcnt + CNT_W'(1);
                end
                // The next seed is the first loaded value left untaken by this group and every earlier one.
                if (!r_found && w_in_set && !(w_taken[0] || w_member)) begin
                    n_found     = 1'b1;
                    n_next_seed = w_value[0];
                end
                if (r_step == IDX_W'(MAX_VALUES - 1)) begin
                    n_state = S_DIV;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            S_DIV: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_avg   = w_quot[VAL_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (r_found) begin
                    n_seed  = r_next_seed;
                    n_step  = '0;
                    n_found = 1'b0;
                    n_sum   = '0;
                    n_gcnt  = '0;
                    n_mask  = '0;
                    n_state = S_PASS;
                end else begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_gcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            r_gcnt  <= n_gcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed      <= n_seed;
        r_next_seed <= n_next_seed;
        r_sum       <= n_sum;
        r_mask      <= n_mask;
        r_avg       <= n_avg;
    end

    assign o_result_valid = (r_state == S_OUT);
    assign o_average      = r_avg;
    assign o_members      = MASK_W'(r_mask);
    assign o_last_group   = !r_found;

    // Every group holds at least its seed.
    a_members_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_members != '0))
        else $error("result beat with an empty member mask");

    // Groups are separated by a full ring turn, so strobes never come back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobes in consecutive cycles");

    // The final group returns the block to loading with an empty set.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_group) |=> (!busy && (r_count == '0)))
        else $error("block not idle after the final group");

    // A beat marked last always starts a grouping run.
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_state == S_START))
        else $error("last beat did not start the grouping");

    // The divider is only ever launched with a nonzero member count.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_gcnt != '0))
        else $error("divider launched with a zero count");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the tolerance value clustering block, with a scoreboard class.
module tb_top;
    import tvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock period in ns.
    localparam int CLK_PERIOD = 4;
    // Roughly how many stored values the directed and random parts feed in together.
    localparam int ITEMS_TARGET = 260;
    // One group costs one ring turn, a divider launch, the bit-serial divide with its
    // done flag and the strobe.
    localparam int GROUP_CYCLES = MAX_VALUES + SUM_W + 3;
    // Cycles left after the last strobe before the register is touched.
    localparam int SETTLE_CYCLES = 8;
    // The longest correct stretch with no beat on any channel is one group, a long
    // sender gap or the closing tail. The watchdog allows several times that.
    localparam int STALL_LIMIT = 10 * GROUP_CYCLES + 1000;
    localparam longint VALUE_TOP = (64'd1 << VAL_W) - 1;

    // One expected group of a set.
    typedef struct packed {
        logic [VAL_W-1:0]  average;
        logic [MASK_W-1:0] members;
        logic              last_group;
    } t_group;

    // Holds its own copy of the tolerance register and of the loaded set, forms the
    // groups when a set closes, and checks the strobed results against them in order.
    class t_cluster_scoreboard;
        logic [VAL_W-1:0] tolerance;
        logic [VAL_W-1:0] value_store [MAX_VALUES];
        int unsigned      load_count;
        t_group           pending_groups[$];
        int unsigned      errors;

        function new();
            tolerance  = TOL_MIN;
            load_count = 0;
            errors     = 0;
        endfunction

        // Values past the capacity of the store are dropped, but a last mark on one of
        // them still closes the set.
        function void note_value(logic [VAL_W-1:0] v, logic last);
            if (load_count < MAX_VALUES) begin
                value_store[load_count] = v;
                load_count++;
            end
            if (last) begin
                form_groups();
                load_count = 0;
            end
        endfunction

        // Leader clustering: the first seed is the first value; each later seed is the
        // first value that no group has taken yet. A group takes every value strictly
        // inside half the tolerance of its seed, already taken values included.
        function void form_groups();
            longint           half;
            longint           seed;
            longint           v;
            logic [MASK_W-1:0] taken;
            logic [SUM_W-1:0] sum;
            logic [SUM_W-1:0] cnt;
            bit               done;
            int unsigned      produced;
            t_group           g;
            // A tolerance under two still behaves as two, so every seed joins its group.
            half     = (tolerance < TOL_MIN) ? 1 : longint'(tolerance) / 2;
            seed     = longint'(value_store[0]);
            taken    = '0;
            done     = 1'b0;
            produced = 0;
            while (!done && produced < MAX_VALUES) begin
                sum       = '0;
                cnt       = '0;
                g.members = '0;
                for (int i = 0; i < load_count; i++) begin
                    v = longint'(value_store[i]);
                    if (v < seed + half && v > seed - half) begin
                        g.members[i] = 1'b1;
                        sum = sum + v[SUM_W-1:0];
                        cnt = cnt + 1'b1;
                    end
                end
                taken = taken | g.members;
                done  = 1'b1;
                for (int i = 0; i < load_count; i++) begin
                    if (!taken[i]) begin
                        seed = longint'(value_store[i]);
                        done = 1'b0;
                        break;
                    end
                end
                g.average    = VAL_W'(sum / cnt);
                g.last_group = done;
                pending_groups.insert(pending_groups.size(), g);
                produced++;
            end
        endfunction

        function void check_group(logic [VAL_W-1:0] avg, logic [MASK_W-1:0] mem,
                                  logic lastg);
            t_group want;
            if (pending_groups.size() == 0) begin
                $error("unexpected group: average %0d, members %h, last_group %0b",
                       avg, mem, lastg);
                errors++;
                return;
            end
            want = pending_groups.pop_front();
            if (avg !== want.average) begin
                $error("average: expected %0d, actual %0d", want.average, avg);
                errors++;
            end
            if (mem !== want.members) begin
                $error("members: expected %h, actual %h", want.members, mem);
                errors++;
            end
            if (lastg !== want.last_group) begin
                $error("last_group: expected %0b, actual %0b", want.last_group, lastg);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [VAL_W-1:0]  i_value;
    logic              i_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [VAL_W-1:0]  i_cfg_data;
    logic              o_result_valid;
    logic [VAL_W-1:0]  o_average;
    logic [MASK_W-1:0] o_members;
    logic              o_last_group;

    t_cluster_scoreboard sb;
    logic [VAL_W-1:0]  set_values[$];
    int unsigned       idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    tolerance_value_clustering DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_average      (o_average),
        .o_members      (o_members),
        .o_last_group   (o_last_group)
    );

    // Results cannot be held off, so every strobe seen at a rising edge is one beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_group(o_average, o_members, o_last_group);
        end
    end

    // Watchdog: any beat on any channel restarts the count of quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Most gaps are zero or short; now and then a long one lands somewhere in the work.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one value at the falling edge and holds start until a rising edge sees busy
    // low. With no gap, start simply stays high for the next value.
    task automatic send_beat(input logic [VAL_W-1:0] v, input logic last, input bit no_gaps);
        int unsigned gap;
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        i_last  <= last;
        do @(posedge i_clk); while (busy);
        sb.note_value(v, last);
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_set(input bit no_gaps);
        for (int i = 0; i < set_values.size(); i++) begin
            send_beat(set_values[i], i == set_values.size() - 1, no_gaps);
        end
    endtask

    // The register moves only while the block is idle: the sender stops, every pending
    // group is drained, and the settle wait of SETTLE_CYCLES passes before the write beat.
    task automatic set_tolerance(input logic [VAL_W-1:0] tol);
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_groups.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tol;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.tolerance = tol;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Spread of register settings: below the floor, small, medium, up to 2**20, any, and the top.
    function automatic logic [VAL_W-1:0] random_tolerance();
        case ($urandom_range(0, 5))
            0: return VAL_W'($urandom_range(0, 1));
            1: return VAL_W'($urandom_range(2, 8));
            2: return VAL_W'($urandom_range(9, 4096));
            3: return VAL_W'($urandom);
            4: return VAL_W'(VALUE_TOP);
            default: return VAL_W'($urandom_range(2, 1 << 20));
        endcase
    endfunction

    // Mostly values scattered around a few random centers, with offsets that often sit
    // right at the window edge, so groups overlap and share members. The rest is noise
    // over the whole range or tiny values with many repeats.
    task automatic build_set(input int unsigned n);
        longint      centers [3];
        longint      half;
        longint      span;
        longint      off;
        longint      v;
        int unsigned ncent;
        int unsigned style;
        half  = (sb.tolerance < TOL_MIN) ? 1 : longint'(sb.tolerance) / 2;
        span  = (2 * half > (64'd1 << 30)) ? (64'd1 << 30) : 2 * half;
        ncent = $urandom_range(1, 3);
        style = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) centers[k] = longint'(VAL_W'($urandom));
        set_values.delete();
        for (int i = 0; i < n; i++) begin
            if (style < 7) begin
                case ($urandom_range(0, 9))
                    0: off = half;
                    1: off = -half;
                    2: off = half - 1;
                    3: off = 1 - half;
                    default: off = longint'($urandom_range(0, 32'(2 * span))) - span;
                endcase
                v = centers[$urandom_range(0, ncent - 1)] + off;
            end else if (style < 9) begin
                v = longint'(VAL_W'($urandom));
            end else begin
                v = $urandom_range(0, 15);
            end
            if (v < 0) v = 0;
            if (v > VALUE_TOP) v = VALUE_TOP;
            set_values.insert(set_values.size(), VAL_W'(v));
        end
    endtask

    initial begin
        int unsigned stored;
        int unsigned set_no;
        int unsigned n;
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = '0;
        i_last      = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The reset tolerance of two comes first: only equal values group.
        set_values = '{VAL_W'(0)};
        send_set(1'b0);
        set_values = '{VAL_W'(VALUE_TOP), VAL_W'(VALUE_TOP - 1)};
        send_set(1'b1);
        set_values = '{VAL_W'(5), VAL_W'(5), VAL_W'(6), VAL_W'(5)};
        send_set(1'b0);
        // Tolerances of zero and one behave as two.
        set_tolerance('0);
        set_values = '{VAL_W'(7), VAL_W'(7), VAL_W'(8)};
        send_set(1'b0);
        set_tolerance(VAL_W'(1));
        set_values = '{VAL_W'(0), VAL_W'(1)};
        send_set(1'b1);
        // Widest window: the extremes land in separate groups, the middle pair in a third.
        set_tolerance(VAL_W'(VALUE_TOP));
        set_values = '{VAL_W'(0), VAL_W'(VALUE_TOP), VAL_W'(1073741823), VAL_W'(1073741822)};
        send_set(1'b0);
        // An odd tolerance truncates its half width.
        set_tolerance(VAL_W'(3));
        set_values = '{VAL_W'(10), VAL_W'(11), VAL_W'(10)};
        send_set(1'b0);
        // Chained windows: later groups take members of earlier ones again.
        set_tolerance(VAL_W'(5));
        set_values = '{VAL_W'(20), VAL_W'(21), VAL_W'(19), VAL_W'(22), VAL_W'(18), VAL_W'(23)};
        send_set(1'b0);
        stored = 25;

        // Random part: whole sets with random content, the register moved now and then.
        set_no = 0;
        while (stored < ITEMS_TARGET) begin
            if (set_no % 5 == 4) set_tolerance(random_tolerance());
            if (set_no == 2) begin
                // A full set of the largest value exercises the widest member sum.
                set_values.delete();
                repeat (MAX_VALUES) set_values.insert(set_values.size(), VAL_W'(VALUE_TOP));
            end else if (set_no == 6 || set_no == 15) begin
                // Overlong sets: the values past capacity are dropped, the last mark is not.
                build_set(MAX_VALUES + $urandom_range(1, 6));
            end else if (set_no == 11) begin
                build_set(MAX_VALUES);
            end else begin
                n = $urandom_range(0, 99);
                if (n < 70) n = $urandom_range(1, 8);
                else if (n < 90) n = $urandom_range(9, 24);
                else n = $urandom_range(25, MAX_VALUES);
                build_set(n);
            end
            send_set($urandom_range(0, 3) == 0);
            n = set_values.size();
            stored += (n > MAX_VALUES) ? MAX_VALUES : n;
            set_no++;
        end

        // Drain: the last groups arrive, then a tail that would catch any stray strobe.
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_groups.size() != 0) @(posedge i_clk);
        repeat (2 * GROUP_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: tolerance_value_clustering.f
hdl/tvc_pkg.sv
hdl/tvc_cell.sv
hdl/tvc_div.sv
hdl/tolerance_value_clustering.sv
verif/tb_top.sv
